// ===== rtl/eipp_pkg.sv =====
// Shared types for the encoder inverse Park PWM block.
package eipp_pkg;

    // Configuration registers as seen by the angle front end
    typedef struct packed {
        logic [15:0] zero_offset;
        logic        reverse_direction;
        logic [6:0]  pair_count;
    } eipp_cfg_t;

    // Classified request handed from the front end to the PWM back end
    typedef struct packed {
        logic [15:0]        mech_angle;
        logic [15:0]        elec_angle;
        logic signed [15:0] angle_step;
        logic signed [15:0] ud_cmd;
        logic signed [15:0] uq_cmd;
    } eipp_item_t;

endpackage

// ===== rtl/encoder_inverse_park_pwm_unit.sv =====
// Top level of the encoder inverse Park PWM block: configuration, queue and assertions.
//
// Input channel (s_*): encoder angle and d/q voltage commands, valid/ready.
// Result channel (m_*): three phase duties, mechanical and electrical angle and
// the signed angle step, valid/ready, one result for every request.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index
// (0 zero offset, 1 reverse direction, 2 pole pairs); other indexes are ignored.
// Write it only while the block is idle.
// A request is registered on acceptance; the front end then forms the angles and
// phase index and pushes them into a two-entry queue once it has room. The back end
// takes one request at a time through the table read, two rotation multiplies,
// two scaling multiplies, rounding, the sqrt(3)/2 multiply, the phase sums and
// duty rounding, while the front end and queue can take further requests meanwhile.
// Reset clears the configuration to offset 0, forward direction, 7 pole pairs, and
// the previous angle to 0; the sine table is a fixed ROM and needs no fill.
// When the receiver stalls, the result register holds, the back end waits with its
// next result finished, the queue fills and s_ready then drops.
module encoder_inverse_park_pwm_unit
    import eipp_pkg::*;
#(
    parameter int ANGLE_BITS   = 16,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_enc_angle,
    input  logic signed [15:0] s_ud_cmd,
    input  logic signed [15:0] s_uq_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_duty_u,
    output logic [15:0]        m_duty_v,
    output logic [15:0]        m_duty_w,
    output logic [15:0]        m_mech_angle,
    output logic [15:0]        m_elec_angle,
    output logic signed [15:0] m_angle_step
);

    localparam int PW = $clog2(SINE_ENTRIES) + 2;
    localparam int QW = $bits(eipp_item_t) + PW;

    localparam logic [1:0] REG_ZERO_OFFSET       = 2'd0;
    localparam logic [1:0] REG_REVERSE_DIRECTION = 2'd1;
    localparam logic [1:0] REG_PAIR_COUNT        = 2'd2;
    localparam logic [6:0] PAIR_COUNT_RESET      = 7'd7;

    eipp_cfg_t     cfg_reg;
    eipp_item_t    front_item;
    logic [PW-1:0] front_phase;
    eipp_item_t    back_item;
    logic [PW-1:0] back_phase;
    logic [QW-1:0] q_wr_data;
    logic [QW-1:0] q_rd_data;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_offset       <= 16'd0;
            cfg_reg.reverse_direction <= 1'b0;
            cfg_reg.pair_count        <= PAIR_COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ZERO_OFFSET:       cfg_reg.zero_offset       <= cfg_wr_data;
                REG_REVERSE_DIRECTION: cfg_reg.reverse_direction <= cfg_wr_data[0];
                REG_PAIR_COUNT:        cfg_reg.pair_count        <= cfg_wr_data[6:0];
                default: begin
                end
            endcase
        end
    end

    eipp_front #(
        .ANGLE_BITS   (ANGLE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .enc_angle (s_enc_angle),
        .ud_cmd    (s_ud_cmd),
        .uq_cmd    (s_uq_cmd),
        .push      (q_push),
        .full      (q_full),
        .item      (front_item),
        .phase     (front_phase)
    );

    assign q_wr_data = {front_item, front_phase};

    eipp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign {back_item, back_phase} = q_rd_data;

    eipp_back #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .empty      (q_empty),
        .pop        (q_pop),
        .item       (back_item),
        .phase      (back_phase),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .duty_u     (m_duty_u),
        .duty_v     (m_duty_v),
        .duty_w     (m_duty_w),
        .mech_angle (m_mech_angle),
        .elec_angle (m_elec_angle),
        .angle_step (m_angle_step)
    );

    a_push_not_full : assert property (
        @(posedge aclk) disable iff (!aresetn) q_push |-> !q_full
    ) else $error("request pushed into a full queue");

    a_pop_not_empty : assert property (
        @(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty
    ) else $error("request popped from an empty queue");

    a_front_busy : assert property (
        @(posedge aclk) disable iff (!aresetn) (s_valid && s_ready) |=> !s_ready
    ) else $error("front end took a request while still forming the previous one");

endmodule

// ===== rtl/eipp_front.sv =====
// Angle front end: accepts requests, forms mechanical/electrical angle, step and phase index.
module eipp_front
    import eipp_pkg::*;
#(
    parameter int ANGLE_BITS   = 16,
    parameter int SINE_ENTRIES = 1024,
    localparam int PW          = $clog2(SINE_ENTRIES) + 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  eipp_cfg_t          cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        enc_angle,
    input  logic signed [15:0] ud_cmd,
    input  logic signed [15:0] uq_cmd,
    output logic               push,
    input  logic               full,
    output eipp_item_t         item,
    output logic [PW-1:0]      phase
);

    localparam int AW = ANGLE_BITS;
    localparam int EB = $clog2(SINE_ENTRIES);
    localparam int SW = AW + EB + 3;

    typedef enum logic {
        FR_IDLE,
        FR_CALC
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      mech_reg;
    logic [AW-1:0]      last_mech_reg;
    logic signed [15:0] step_reg;
    logic signed [15:0] ud_reg;
    logic signed [15:0] uq_reg;

    logic [AW-1:0]      enc_a;
    logic [AW-1:0]      off_a;
    logic [AW-1:0]      mech;
    logic [AW-1:0]      diff;
    logic [AW+6:0]      elec_prod;
    logic [AW-1:0]      elec;
    logic [SW-1:0]      phase_sum;

    always_comb begin
        enc_a = AW'(enc_angle);
        off_a = AW'(cfg.zero_offset);
        mech  = cfg.reverse_direction ? (off_a - enc_a) : (off_a + enc_a);
        diff  = mech - last_mech_reg;
    end

    // Electrical angle wraps by keeping the low angle bits of the product
    assign elec_prod = {7'd0, mech_reg} * {{AW{1'b0}}, cfg.pair_count};
    assign elec      = elec_prod[AW-1:0];

    // Round to the nearest table step; the spare top bit drops a full-turn result to zero
    assign phase_sum = (SW'(elec) << (EB + 2)) + (SW'(1) << (AW - 1));
    assign phase     = phase_sum[AW +: PW];

    assign item.mech_angle = 16'(mech_reg);
    assign item.elec_angle = 16'(elec);
    assign item.angle_step = step_reg;
    assign item.ud_cmd     = ud_reg;
    assign item.uq_cmd     = uq_reg;

    assign s_ready = aresetn && (state_reg == FR_IDLE);
    assign push    = (state_reg == FR_CALC) && !full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FR_IDLE;
            last_mech_reg <= '0;
        end else begin
            unique case (state_reg)
                FR_IDLE: begin
                    if (s_valid) begin
                        mech_reg      <= mech;
                        last_mech_reg <= mech;
                        step_reg      <= 16'($signed(diff));
                        ud_reg        <= ud_cmd;
                        uq_reg        <= uq_cmd;
                        state_reg     <= FR_CALC;
                    end
                end
                FR_CALC: begin
                    // hold until the queue has room
                    if (!full) begin
                        state_reg <= FR_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/eipp_queue.sv =====
// Two-entry request queue between the angle front end and the PWM back end.
module eipp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int DEPTH = 2;
    localparam int PTRW  = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                mem[wr_ptr_reg] <= wr_data;
                wr_ptr_reg      <= wr_ptr_reg + PTRW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTRW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/eipp_back.sv =====
// PWM back end: sine lookup, inverse Park/Clarke, duty rounding and the result register.
module eipp_back
    import eipp_pkg::*;
#(
    parameter int SINE_ENTRIES = 1024,
    localparam int PW          = $clog2(SINE_ENTRIES) + 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               empty,
    output logic               pop,
    input  eipp_item_t         item,
    input  logic [PW-1:0]      phase,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        duty_u,
    output logic [15:0]        duty_v,
    output logic [15:0]        duty_w,
    output logic [15:0]        mech_angle,
    output logic [15:0]        elec_angle,
    output logic signed [15:0] angle_step
);

    localparam int EB = $clog2(SINE_ENTRIES);
    localparam int XW = 54;
    localparam int SINE_TERMS = 12;
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [16:0] K099_Q16    = 17'sd64881;
    localparam logic signed [16:0] SQRT3_2_Q16 = 17'sd56756;
    localparam logic signed [17:0] UNIT_Q16    = 18'sd65536;
    localparam logic signed [XW-1:0] HALF_Q48  = XW'(48'h8000_0000_0000);

    typedef logic [15:0] sine_rom_t [SINE_ENTRIES];

    // Shift-and-subtract quotient for the series terms, evaluated at elaboration
    function automatic logic [63:0] series_quot(input logic [63:0] num,
                                                input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        int          i;
        quo = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine in Q16 from a Q30 Taylor series, evaluated at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        logic [63:0] div;
        int          k;
        int          n;
        for (k = 0; k < SINE_ENTRIES; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) >> EB;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (n = 1; n <= SINE_TERMS; n++) begin
                div  = 64'((2 * n) * (2 * n + 1));
                term = series_quot((term * x2) >> 30, div);
                if (n[0]) sum = sum - term;
                else      sum = sum + term;
            end
            v = (sum + 64'd8192) >> 14;
            rom[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Round a Q48 product to Q32, half away from zero
    function automatic logic signed [35:0] round_q16(input logic signed [51:0] x);
        logic signed [51:0] t;
        logic signed [35:0] r;
        if (!x[51]) begin
            t = x + 52'sd32768;
            r = t[51:16];
        end else begin
            t = -x + 52'sd32768;
            r = -$signed(t[51:16]);
        end
        return r;
    endfunction

    // Round Q48 to Q16 and clamp to the duty range
    function automatic logic [15:0] sat_duty(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] t;
        logic [XW-33:0]       hi;
        logic [15:0]          d;
        if (x[XW-1]) begin
            d = 16'd0;
        end else begin
            t  = x + XW'(33'h0_8000_0000);
            hi = t[XW-1:32];
            d  = (hi > (XW-32)'(16'hFFFF)) ? 16'hFFFF : hi[15:0];
        end
        return d;
    endfunction

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL_A,
        BK_MUL_B,
        BK_SCALE_A,
        BK_SCALE_B,
        BK_ROUND,
        BK_SQ3,
        BK_SUM,
        BK_OUT
    } state_t;

    state_t             state_reg;
    eipp_item_t         item_reg;
    logic [15:0]        sin_rom_reg;
    logic [15:0]        cos_rom_reg;
    logic               sin_full_reg;
    logic               cos_full_reg;
    logic               sin_neg_reg;
    logic               cos_neg_reg;
    logic signed [34:0] a_reg;
    logic signed [34:0] b_reg;
    logic signed [51:0] scale_a_reg;
    logic signed [51:0] scale_b_reg;
    logic signed [35:0] ua_reg;
    logic signed [35:0] ub_reg;
    logic signed [52:0] ubk_reg;
    logic signed [XW-1:0] u_reg;
    logic signed [XW-1:0] v_reg;
    logic signed [XW-1:0] w_reg;
    logic               m_valid_reg;
    logic [15:0]        duty_u_reg;
    logic [15:0]        duty_v_reg;
    logic [15:0]        duty_w_reg;
    logic [15:0]        mech_angle_reg;
    logic [15:0]        elec_angle_reg;
    logic signed [15:0] angle_step_reg;

    logic [1:0]         q_s;
    logic [1:0]         q_c;
    logic [EB-1:0]      r_idx;
    logic [EB-1:0]      addr_s;
    logic [EB-1:0]      addr_c;
    logic signed [17:0] s_mag;
    logic signed [17:0] c_mag;
    logic signed [17:0] s_val;
    logic signed [17:0] c_val;
    logic signed [15:0] op_c;
    logic signed [15:0] op_s;
    logic signed [33:0] prod_c;
    logic signed [33:0] prod_s;
    logic signed [34:0] rot_sum;
    logic signed [34:0] scale_in;
    logic signed [51:0] scale_prod;
    logic signed [XW-1:0] ua_x;
    logic signed [XW-1:0] ubk_x;
    logic               out_free;

    // Quadrant symmetry; cosine sits one quadrant ahead of sine
    always_comb begin
        q_s    = phase[PW-1 -: 2];
        q_c    = q_s + 2'd1;
        r_idx  = phase[EB-1:0];
        addr_s = q_s[0] ? (~r_idx + EB'(1)) : r_idx;
        addr_c = q_c[0] ? (~r_idx + EB'(1)) : r_idx;
    end

    always_comb begin
        s_mag = sin_full_reg ? UNIT_Q16 : $signed({2'b00, sin_rom_reg});
        c_mag = cos_full_reg ? UNIT_Q16 : $signed({2'b00, cos_rom_reg});
        s_val = sin_neg_reg ? -s_mag : s_mag;
        c_val = cos_neg_reg ? -c_mag : c_mag;
    end

    // Shared rotation multipliers: a = ud*c - uq*s, then b = uq*c + ud*s
    assign op_c    = (state_reg == BK_MUL_A) ? item_reg.ud_cmd : item_reg.uq_cmd;
    assign op_s    = (state_reg == BK_MUL_A) ? item_reg.uq_cmd : item_reg.ud_cmd;
    assign prod_c  = 34'(op_c) * 34'(c_val);
    assign prod_s  = 34'(op_s) * 34'(s_val);
    assign rot_sum = (state_reg == BK_MUL_A) ? (35'(prod_c) - 35'(prod_s))
                                             : (35'(prod_c) + 35'(prod_s));

    // Shared 0.99 scaling multiplier
    assign scale_in   = (state_reg == BK_SCALE_A) ? a_reg : b_reg;
    assign scale_prod = 52'(scale_in) * 52'(K099_Q16);

    assign ua_x  = XW'(ua_reg);
    assign ubk_x = XW'(ubk_reg);

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == BK_IDLE) && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // raise valid as a finished request leaves, drop it once taken
            if ((state_reg == BK_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                BK_IDLE: begin
                    if (!empty) begin
                        item_reg     <= item;
                        sin_rom_reg  <= SINE_ROM[addr_s];
                        cos_rom_reg  <= SINE_ROM[addr_c];
                        sin_full_reg <= q_s[0] && (r_idx == '0);
                        cos_full_reg <= q_c[0] && (r_idx == '0);
                        sin_neg_reg  <= q_s[1];
                        cos_neg_reg  <= q_c[1];
                        state_reg    <= BK_MUL_A;
                    end
                end
                BK_MUL_A: begin
                    a_reg     <= rot_sum;
                    state_reg <= BK_MUL_B;
                end
                BK_MUL_B: begin
                    b_reg     <= rot_sum;
                    state_reg <= BK_SCALE_A;
                end
                BK_SCALE_A: begin
                    scale_a_reg <= scale_prod;
                    state_reg   <= BK_SCALE_B;
                end
                BK_SCALE_B: begin
                    scale_b_reg <= scale_prod;
                    state_reg   <= BK_ROUND;
                end
                BK_ROUND: begin
                    ua_reg    <= round_q16(scale_a_reg);
                    ub_reg    <= round_q16(scale_b_reg);
                    state_reg <= BK_SQ3;
                end
                BK_SQ3: begin
                    ubk_reg   <= 53'(ub_reg) * 53'(SQRT3_2_Q16);
                    state_reg <= BK_SUM;
                end
                BK_SUM: begin
                    // W folds to half minus the alpha half-term minus the beta term
                    u_reg     <= HALF_Q48 + (ua_x <<< 16);
                    v_reg     <= HALF_Q48 - (ua_x <<< 15) + ubk_x;
                    w_reg     <= HALF_Q48 - (ua_x <<< 15) - ubk_x;
                    state_reg <= BK_OUT;
                end
                BK_OUT: begin
                    // hold the finished request until the result register is free
                    if (out_free) begin
                        duty_u_reg     <= sat_duty(u_reg);
                        duty_v_reg     <= sat_duty(v_reg);
                        duty_w_reg     <= sat_duty(w_reg);
                        mech_angle_reg <= item_reg.mech_angle;
                        elec_angle_reg <= item_reg.elec_angle;
                        angle_step_reg <= item_reg.angle_step;
                        state_reg      <= BK_IDLE;
                    end
                end
                default: begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign duty_u     = duty_u_reg;
    assign duty_v     = duty_v_reg;
    assign duty_w     = duty_w_reg;
    assign mech_angle = mech_angle_reg;
    assign elec_angle = elec_angle_reg;
    assign angle_step = angle_step_reg;

endmodule

// ===== bench/encoder_inverse_park_pwm_unit_tb.sv =====
// Self-checking testbench for the encoder inverse Park PWM unit.
`timescale 1ns / 100ps

module encoder_inverse_park_pwm_unit_tb;
    import eipp_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          TABLE_SIZE   = 1024;
    localparam int unsigned PHASE_STEPS  = 4 * TABLE_SIZE;
    localparam int          DRAIN_CYCLES = 12;

    localparam logic [1:0] REG_ZERO_OFFSET = 2'd0;
    localparam logic [1:0] REG_REVERSE_DIR = 2'd1;
    localparam logic [1:0] REG_PAIR_COUNT  = 2'd2;
    localparam logic [1:0] REG_UNUSED      = 2'd3;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          GAIN_099    = 64'sd64881;
    localparam longint          SQRT3_HALF  = 64'sd56756;
    localparam longint          DUTY_HALF   = 64'sh0000_8000_0000_0000;
    localparam longint          DUTY_SUM    = 64'sh0001_8000_0000_0000;

    typedef struct packed {
        logic [15:0]        duty_u;
        logic [15:0]        duty_v;
        logic [15:0]        duty_w;
        logic [15:0]        mech_angle;
        logic [15:0]        elec_angle;
        logic signed [15:0] angle_step;
    } phase_duties_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [15:0]        s_enc_angle;
    logic signed [15:0] s_ud_cmd;
    logic signed [15:0] s_uq_cmd;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_duty_u;
    logic [15:0]        m_duty_v;
    logic [15:0]        m_duty_w;
    logic [15:0]        m_mech_angle;
    logic [15:0]        m_elec_angle;
    logic signed [15:0] m_angle_step;

    // Predictor state
    eipp_cfg_t     shadow_cfg;
    logic [15:0]   prev_mech;
    logic [15:0]   sine_rom [TABLE_SIZE];
    phase_duties_t pending_duties [$];

    int errors;
    int cycle_count;
    bit gaps_on;

    encoder_inverse_park_pwm_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_enc_angle  (s_enc_angle),
        .s_ud_cmd     (s_ud_cmd),
        .s_uq_cmd     (s_uq_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_duty_u     (m_duty_u),
        .m_duty_v     (m_duty_v),
        .m_duty_w     (m_duty_w),
        .m_mech_angle (m_mech_angle),
        .m_elec_angle (m_elec_angle),
        .m_angle_step (m_angle_step)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Signed sine in Q16 from the quarter-wave table
    function automatic longint sine_at(input int unsigned p);
        int unsigned quad;
        int unsigned r;
        longint      m;
        quad = (p / TABLE_SIZE) & 3;
        r    = p % TABLE_SIZE;
        if (quad[0]) begin
            m = (r == 0) ? 64'sd65536 : longint'(sine_rom[TABLE_SIZE - r]);
        end else begin
            m = longint'(sine_rom[r]);
        end
        return (quad >= 2) ? -m : m;
    endfunction

    function automatic longint round_half_away(input longint x, input int s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (x >= 0) begin
            return (x + half) >>> s;
        end
        return -((-x + half) >>> s);
    endfunction

    function automatic logic [15:0] sat_duty(input longint x);
        longint unsigned t;
        if (x < 0) begin
            return 16'h0000;
        end
        t = (longint'(x) + 64'sd2147483648) >>> 32;
        return (t > 64'd65535) ? 16'hFFFF : t[15:0];
    endfunction

    // Advances the previous-angle state as a side effect
    function automatic phase_duties_t predict_phase_duties(input logic [15:0] enc,
                                                          input logic signed [15:0] ud,
                                                          input logic signed [15:0] uq);
        phase_duties_t res;
        logic [15:0]   mech;
        logic [15:0]   elec;
        logic [15:0]   diff;
        int unsigned   e32;
        int unsigned   p;
        longint        ud_l, uq_l, sn, cs, a, b, ua, ub, u, v, w;
        mech = shadow_cfg.reverse_direction ? (shadow_cfg.zero_offset - enc)
                                            : (shadow_cfg.zero_offset + enc);
        elec = mech * shadow_cfg.pair_count;
        diff = mech - prev_mech;
        prev_mech = mech;

        e32 = elec;
        p   = ((e32 * PHASE_STEPS) + 32'd32768) >> 16;
        p   = p % PHASE_STEPS;
        sn  = sine_at(p);
        cs  = sine_at((p + TABLE_SIZE) % PHASE_STEPS);

        ud_l = ud;
        uq_l = uq;
        a  = ud_l * cs - uq_l * sn;
        b  = uq_l * cs + ud_l * sn;
        ua = round_half_away(a * GAIN_099, 16);
        ub = round_half_away(b * GAIN_099, 16);
        u  = DUTY_HALF + ua * 64'sd65536;
        v  = DUTY_HALF - ua * 64'sd32768 + ub * SQRT3_HALF;
        w  = DUTY_SUM - u - v;

        res.duty_u     = sat_duty(u);
        res.duty_v     = sat_duty(v);
        res.duty_w     = sat_duty(w);
        res.mech_angle = mech;
        res.elec_angle = elec;
        res.angle_step = diff;
        return res;
    endfunction

    function automatic logic signed [15:0] pick_command();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic send_request(input logic [15:0] enc, input logic signed [15:0] ud,
                                input logic signed [15:0] uq);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     = 1'b1;
        s_enc_angle = enc;
        s_ud_cmd    = ud;
        s_uq_cmd    = uq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_duties.push_back(predict_phase_duties(enc, ud, uq));
    endtask

    // Drop valid and hold until every outstanding request has returned
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_duties.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        logic [15:0] noise;
        logic [15:0] data;
        drain_results();
        noise = 16'($urandom);
        // fill unused upper bits with noise
        case (idx)
            REG_REVERSE_DIR: data = {noise[15:1], value[0]};
            REG_PAIR_COUNT:  data = {noise[15:7], value[6:0]};
            default:         data = value;
        endcase
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_ZERO_OFFSET: shadow_cfg.zero_offset       = data;
            REG_REVERSE_DIR: shadow_cfg.reverse_direction = data[0];
            REG_PAIR_COUNT:  shadow_cfg.pair_count        = data[6:0];
            default: ;
        endcase
    endtask

    task automatic test_first_item();
        // step taken against a zero previous angle, default pole pairs
        send_request(16'h1234, 16'sh4000, 16'sh0000);
    endtask

    task automatic test_field_extremes();
        send_request(16'h0000, 16'sh0000, 16'sh0000);
        send_request(16'hFFFF, 16'sh7FFF, 16'sh7FFF);
        send_request(16'h0000, 16'sh8000, 16'sh8000);
        send_request(16'hFFFF, 16'sh7FFF, 16'sh8000);
        send_request(16'h2000, 16'sh8000, 16'sh7FFF);
        send_request(16'h4000, 16'sh7FFF, 16'sh0000);
        send_request(16'h8000, 16'sh0000, 16'sh8000);
        send_request(16'h5555, 16'shAAAA, 16'sh5555);
    endtask

    task automatic test_half_turn_step();
        send_request(16'h0100, 16'sh1000, 16'sh2000);
        send_request(16'h8100, 16'sh1000, 16'sh2000);
        send_request(16'h0100, 16'sh1000, 16'sh2000);
    endtask

    task automatic test_register_edges();
        write_register(REG_PAIR_COUNT, 16'd0);
        send_request(16'h3C00, 16'sh7FFF, 16'sh1234);
        send_request(16'hC3FF, 16'sh8000, 16'sh7FFF);
        write_register(REG_PAIR_COUNT, 16'd127);
        send_request(16'h0123, 16'sh3000, 16'shD000);
        send_request(16'hFEDC, 16'sh7FFF, 16'sh7FFF);
        write_register(REG_ZERO_OFFSET, 16'hFFFF);
        write_register(REG_REVERSE_DIR, 16'd1);
        send_request(16'h0001, 16'sh2000, 16'sh2000);
        send_request(16'hFFFF, 16'sh8000, 16'sh0000);
        // full-scale duty at forty-five degrees
        write_register(REG_ZERO_OFFSET, 16'h0000);
        write_register(REG_REVERSE_DIR, 16'd0);
        write_register(REG_PAIR_COUNT, 16'd1);
        send_request(16'h2000, 16'sh7FFF, 16'sh8000);
        send_request(16'hA000, 16'sh7FFF, 16'sh8000);
    endtask

    task automatic test_unknown_index();
        write_register(REG_UNUSED, 16'hFFFF);
        send_request(16'h6000, 16'sh1111, 16'shEEEE);
        send_request(16'h9000, 16'sh7000, 16'sh9000);
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 40; i++) begin
            if (i == 30) begin
                drain_results();
            end
            send_request(16'($urandom), pick_command(), pick_command());
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0] walk;
        logic [15:0] enc;
        walk = 16'($urandom);
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_register(REG_ZERO_OFFSET, 16'h0000);
                    write_register(REG_REVERSE_DIR, 16'd0);
                    write_register(REG_PAIR_COUNT, 16'd1);
                end
                1: begin
                    write_register(REG_ZERO_OFFSET, 16'hFFFF);
                    write_register(REG_REVERSE_DIR, 16'd1);
                    write_register(REG_PAIR_COUNT, 16'd64);
                end
                2: begin
                    write_register(REG_ZERO_OFFSET, 16'($urandom));
                    write_register(REG_REVERSE_DIR, 16'd0);
                    write_register(REG_PAIR_COUNT, 16'd0);
                end
                3: begin
                    write_register(REG_ZERO_OFFSET, 16'($urandom));
                    write_register(REG_REVERSE_DIR, 16'd1);
                    write_register(REG_PAIR_COUNT, 16'd127);
                end
                default: begin
                    write_register(REG_ZERO_OFFSET, 16'($urandom));
                    write_register(REG_REVERSE_DIR, 16'($urandom_range(0, 1)));
                    write_register(REG_PAIR_COUNT, 16'($urandom_range(1, 64)));
                end
            endcase
            // last phase runs flat out on both sides
            gaps_on = (ph != 7);
            for (int i = 0; i < 110; i++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2: enc = 16'($urandom);
                    3, 4:    enc = walk ^ 16'h8000;
                    5:       enc = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: enc = walk + 16'($urandom_range(0, 4095)) - 16'd2048;
                endcase
                walk = enc;
                send_request(enc, pick_command(), pick_command());
            end
        end
    endtask

    // Receiver stalls in random bursts
    initial begin
        int hold;
        hold    = 0;
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                hold    = $urandom_range(0, 7);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_duties.size() == 0) begin
                $display("%0t ns: result with none expected, duties %h %h %h", $time,
                         m_duty_u, m_duty_v, m_duty_w);
                errors++;
            end else begin
                phase_duties_t want;
                want = pending_duties.pop_front();
                check_field("duty_u", want.duty_u, m_duty_u);
                check_field("duty_v", want.duty_v, m_duty_v);
                check_field("duty_w", want.duty_w, m_duty_w);
                check_field("mech_angle", want.mech_angle, m_mech_angle);
                check_field("elec_angle", want.elec_angle, m_elec_angle);
                check_field("angle_step", want.angle_step, m_angle_step);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        longint unsigned x, x2, term, sum, v;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_ZERO_OFFSET;
        cfg_wr_data = 16'h0000;
        s_valid     = 1'b0;
        s_enc_angle = 16'h0000;
        s_ud_cmd    = 16'sh0000;
        s_uq_cmd    = 16'sh0000;
        errors      = 0;
        gaps_on     = 1'b1;

        shadow_cfg.zero_offset       = 16'h0000;
        shadow_cfg.reverse_direction = 1'b0;
        shadow_cfg.pair_count        = 7'd7;
        prev_mech                    = 16'h0000;

        // quarter-wave sine by an integer Taylor series in Q30
        for (int k = 0; k < TABLE_SIZE; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) / TABLE_SIZE;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (longint unsigned n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum + 64'd8192) >> 14;
            sine_rom[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        end

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_first_item();
        test_field_extremes();
        test_half_turn_step();
        test_register_edges();
        test_unknown_index();
        test_drain_pause();
        test_random_traffic();

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_duties.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/eipp_pkg.sv
rtl/eipp_front.sv
rtl/eipp_queue.sv
rtl/eipp_back.sv
rtl/encoder_inverse_park_pwm_unit.sv
bench/encoder_inverse_park_pwm_unit_tb.sv
